FILE: hdl/dfr_pkg.sv
// dfr_pkg: shared constants, types and codes of the length framed byte deframer
// no dependencies; compiled first
`default_nettype none

package dfr_pkg;

    // largest frame the buffer holds, in bytes
    localparam int MAX_FRAME = 1024;

    // write position must reach MAX_FRAME itself after the tail byte
    localparam int WIDX_W = $clog2(MAX_FRAME + 1);
    // payload byte count stays below MAX_FRAME
    localparam int CNT_W  = $clog2(MAX_FRAME);

    localparam logic [16:0] FRAME_LIMIT = 17'(MAX_FRAME);
    localparam logic [16:0] FRAME_OVERHEAD = 17'd6;

    localparam logic [7:0] CTRL_MASK  = 8'hF0;
    localparam logic [7:0] HEAD_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET = 8'h55;

    localparam int STORE_INDEX_W  = 10;
    localparam int FRAME_LENGTH_W = 11;

    // configuration register indexes
    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CTRL  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_DONE     = 3'd1,
        EV_BAD_HEAD = 3'd2,
        EV_BAD_CTRL = 3'd3,
        EV_BAD_TAIL = 3'd4,
        EV_OVERFLOW = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
    } cfg_t;

    typedef struct packed {
        logic                      store_valid;
        logic [STORE_INDEX_W-1:0]  store_index;
        logic [7:0]                store_byte;
        event_t                    event_code;
        logic [FRAME_LENGTH_W-1:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/dfr_in_if.sv
// dfr_in_if: request channel carrying one received link byte
// depends on nothing but the valid/ready handshake convention
`default_nettype none

interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/dfr_out_if.sv
// dfr_out_if: result channel carrying store and event fields per request
// depends on dfr_pkg for field widths
`default_nettype none

interface dfr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                store_valid;
    logic [dfr_pkg::STORE_INDEX_W-1:0]   store_index;
    logic [7:0]                          store_byte;
    logic [2:0]                          event_code;
    logic [dfr_pkg::FRAME_LENGTH_W-1:0]  frame_length;

    modport source (output valid, output store_valid, output store_index,
                    output store_byte, output event_code, output frame_length,
                    input ready);
    modport sink   (input valid, input store_valid, input store_index,
                    input store_byte, input event_code, input frame_length,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/length_framed_byte_deframer.sv
// length_framed_byte_deframer: a request passes the input register, then the result
// register; throughput one byte per cycle while the result channel is drained
// a request is taken while a result waits, as long as the input register is free
// reset: async active low, parser idle, counters zero, head 0xAA, tail 0x55
// top level: input register, parser and result register; uses dfr_pkg,
// dfr_in_if, dfr_out_if, dfr_cfg_regs and dfr_parser
`default_nettype none

module length_framed_byte_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    dfr_in_if.sink           link,
    dfr_out_if.source        result,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [7:0]  wr_data
);
    import dfr_pkg::*;

    cfg_t       cfg;
    result_t    step_res;
    result_t    res_reg;
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg;
    logic       advance;

    // held byte moves on when the result register is empty or being drained
    assign advance     = in_vld_reg && (!out_vld_reg || result.ready);
    assign link.ready  = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (link.ready)
                in_vld_reg <= link.valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link.ready && link.valid)
            in_byte_reg <= link.in_byte;
        if (advance)
            res_reg <= step_res;
    end

    dfr_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    dfr_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign result.valid        = out_vld_reg;
    assign result.store_valid  = res_reg.store_valid;
    assign result.store_index  = res_reg.store_index;
    assign result.store_byte   = res_reg.store_byte;
    assign result.event_code   = res_reg.event_code;
    assign result.frame_length = res_reg.frame_length;

endmodule

`default_nettype wire

FILE: hdl/dfr_cfg_regs.sv
// dfr_cfg_regs: head and tail match byte registers behind the write port
// depends on dfr_pkg
`default_nettype none

module dfr_cfg_regs
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [7:0]  wr_data,
    output dfr_pkg::cfg_t    cfg
);
    import dfr_pkg::*;

    logic [7:0] head_reg;
    logic [7:0] tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HEAD: head_reg <= wr_data;
                REG_TAIL: tail_reg <= wr_data;
                default:  head_reg <= head_reg;
            endcase
        end
    end

    assign cfg.head_byte = head_reg;
    assign cfg.tail_byte = tail_reg;

endmodule

`default_nettype wire

FILE: hdl/dfr_parser.sv
// dfr_parser: frame phase machine, counters and per-byte result logic
// depends on dfr_pkg; driven by the input register of the top level
`default_nettype none

module dfr_parser
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step_en,
    input  wire logic [7:0]    in_byte,
    input  wire dfr_pkg::cfg_t cfg,
    output dfr_pkg::result_t   res
);
    import dfr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [15:0]        pl_reg, pl_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pl_reg    <= '0;
            cnt_reg   <= '0;
            widx_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pl_reg    <= pl_next;
            cnt_reg   <= cnt_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb
    begin
        logic [WIDX_W-1:0]                widx_base;
        logic [WIDX_W-1:0]                widx_inc;
        logic [CNT_W-1:0]                 cnt_inc;
        logic [16:0]                      len_total;
        logic                             store;
        event_t                           ev;
        logic [WIDX_W+STORE_INDEX_W-1:0]  idx_ext;
        logic [WIDX_W+FRAME_LENGTH_W-1:0] len_ext;
        logic                             done;

        phase_next = phase_reg;
        pl_next    = pl_reg;
        cnt_next   = cnt_reg;
        store      = 1'b0;
        ev         = EV_NONE;
        done       = 1'b0;
        cnt_inc    = cnt_reg + CNT_W'(1);
        len_total  = '0;
        widx_base  = widx_reg;

        unique case (phase_reg)
            PH_CTRL:
            begin
                if ((in_byte & CTRL_MASK) != 8'h00)
                begin
                    store      = 1'b1;
                    phase_next = PH_LEN;
                end
                else
                begin
                    ev         = EV_BAD_CTRL;
                    phase_next = PH_IDLE;
                end
            end
            PH_LEN:
            begin
                store   = 1'b1;
                pl_next = {pl_reg[7:0], in_byte};
                if (cnt_reg == CNT_W'(1))
                begin
                    // second length byte: frame size check
                    cnt_next  = '0;
                    len_total = {1'b0, pl_next} + FRAME_OVERHEAD;
                    if (len_total > FRAME_LIMIT)
                    begin
                        ev         = EV_OVERFLOW;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_DATA:
            begin
                store = 1'b1;
                if (pl_reg != 16'h0000)
                begin
                    if (cnt_inc == pl_reg[CNT_W-1:0])
                    begin
                        phase_next = PH_CHECK;
                        cnt_next   = '0;
                        pl_next    = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    // empty payload: this byte is the check byte
                    cnt_next   = '0;
                    phase_next = PH_TAIL;
                end
            end
            PH_CHECK:
            begin
                store      = 1'b1;
                cnt_next   = '0;
                phase_next = PH_TAIL;
            end
            PH_TAIL:
            begin
                if (in_byte == cfg.tail_byte)
                begin
                    store = 1'b1;
                    ev    = EV_DONE;
                    done  = 1'b1;
                end
                else
                begin
                    ev = EV_BAD_TAIL;
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                // idle and unused codes: counters cleared, byte is the head
                pl_next   = '0;
                cnt_next  = '0;
                widx_base = '0;
                if (in_byte == cfg.head_byte)
                begin
                    store      = 1'b1;
                    phase_next = PH_CTRL;
                end
                else
                begin
                    ev         = EV_BAD_HEAD;
                    phase_next = PH_IDLE;
                end
            end
        endcase

        widx_inc  = widx_base + WIDX_W'(1);
        widx_next = store ? widx_inc : widx_base;

        idx_ext = {{STORE_INDEX_W{1'b0}}, widx_base};
        len_ext = {{FRAME_LENGTH_W{1'b0}}, widx_inc};

        res.store_valid  = store;
        res.store_index  = store ? idx_ext[STORE_INDEX_W-1:0] : '0;
        res.store_byte   = store ? in_byte : 8'h00;
        res.event_code   = ev;
        res.frame_length = done ? len_ext[FRAME_LENGTH_W-1:0] : '0;
    end

`ifndef SYNTHESIS
    a_done_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.event_code == EV_DONE) |-> res.store_valid)
        else $error("frame complete without storing the tail byte");

    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN) |-> (cnt_reg <= CNT_W'(1)))
        else $error("length byte count beyond two bytes");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |->
            ((pl_reg == 16'h0000) || (cnt_reg < pl_reg[CNT_W-1:0])))
        else $error("payload count passed the payload length");

    a_widx_started: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (widx_reg != '0))
        else $error("frame in progress with empty buffer position");

    a_widx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> ({{(32-WIDX_W){1'b0}}, widx_reg} <= 32'(MAX_FRAME)))
        else $error("buffer position beyond the frame limit");
`endif

endmodule

`default_nettype wire
